>>> rtl/ptr_pkg.sv
// Shared types and constants for the proportional text rasterizer.
`timescale 1ns / 1ps

package ptr_pkg;

  // Font attribute memory packs this many slots into one row.
  localparam int unsigned LANES  = 8;
  localparam int unsigned LANE_W = 3;

  // Per-slot glyph attributes.
  typedef struct packed {
    logic [7:0] code;
    logic [4:0] height;
    logic [4:0] width;
  } meta_t;

  // Write request into the font store.
  typedef struct packed {
    logic        meta_we;
    logic        pix_we;
    logic [7:0]  slot;
    logic        in_use;
    meta_t       meta;
    logic [4:0]  row;
    logic [15:0] bits;
  } font_wr_t;

endpackage

>>> rtl/ptr_req_if.sv
// Input request channel of the text rasterizer.
`timescale 1ns / 1ps

interface ptr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  char_code;
  logic [6:0]  glyph_slot;
  logic [4:0]  glyph_height;
  logic [4:0]  glyph_width;
  logic        glyph_valid;
  logic [3:0]  glyph_row;
  logic [15:0] row_bits;

  modport source (
    output valid, command, char_code, glyph_slot, glyph_height, glyph_width,
           glyph_valid, glyph_row, row_bits,
    input  ready
  );

  modport sink (
    input  valid, command, char_code, glyph_slot, glyph_height, glyph_width,
           glyph_valid, glyph_row, row_bits,
    output ready
  );
endinterface

>>> rtl/ptr_rsp_if.sv
// Result channel of the text rasterizer.
`timescale 1ns / 1ps

interface ptr_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  board_row;
  logic [7:0]  board_col;
  logic [15:0] span_bits;
  logic [15:0] cursor_row;
  logic [8:0]  cursor_col;
  logic        last;

  modport source (
    output valid, status, board_row, board_col, span_bits, cursor_row, cursor_col, last,
    input  ready
  );

  modport sink (
    input  valid, status, board_row, board_col, span_bits, cursor_row, cursor_col, last,
    output ready
  );
endinterface

>>> rtl/ptr_font_store.sv
// Font store: slot valid bits, slot attribute memory and glyph pixel memory.
`timescale 1ns / 1ps

module ptr_font_store import ptr_pkg::*; #(
  parameter int GLYPH_SLOTS = 128,
  parameter int GLYPH_ROWS  = 16,
  localparam int SROWS      = (GLYPH_SLOTS + LANES - 1) / LANES,
  localparam int SROW_W     = (SROWS > 1) ? $clog2(SROWS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  font_wr_t              wr_i,
  input  logic [SROW_W-1:0]     meta_raddr_i,
  output meta_t [LANES-1:0]     meta_rdata_o,
  output logic  [LANES-1:0]     use_rdata_o,
  input  logic [7:0]            pix_rslot_i,
  input  logic [4:0]            pix_rrow_i,
  output logic [15:0]           pix_rdata_o
);

  localparam int SLOT_W    = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
  localparam int ROW_W     = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int PIX_AW    = SLOT_W + ROW_W;
  localparam int PIX_DEPTH = 1 << PIX_AW;

  logic [SROWS-1:0][LANES-1:0] in_use_q;
  meta_t [LANES-1:0]           meta_mem [SROWS];
  logic [15:0]                 pix_mem  [PIX_DEPTH];

  logic [SROW_W-1:0] wr_srow;
  logic [LANE_W-1:0] wr_lane;
  logic [PIX_AW-1:0] pix_waddr;
  logic [PIX_AW-1:0] pix_raddr;

  assign wr_srow   = wr_i.slot[LANE_W +: SROW_W];
  assign wr_lane   = wr_i.slot[LANE_W-1:0];
  assign pix_waddr = {wr_i.slot[SLOT_W-1:0], wr_i.row[ROW_W-1:0]};
  assign pix_raddr = {pix_rslot_i[SLOT_W-1:0], pix_rrow_i[ROW_W-1:0]};

  // valid bits: cleared at reset, read alongside the attribute row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      use_rdata_o <= '0;
    end else begin
      if (wr_i.meta_we) begin
        in_use_q[wr_srow][wr_lane] <= wr_i.in_use;
      end
      use_rdata_o <= in_use_q[meta_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.meta_we) begin
      meta_mem[wr_srow][wr_lane] <= wr_i.meta;
    end
    meta_rdata_o <= meta_mem[meta_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.pix_we) begin
      pix_mem[pix_waddr] <= wr_i.bits;
    end
    pix_rdata_o <= pix_mem[pix_raddr];
  end

endmodule

>>> rtl/proportional_text_rasterizer_unit.sv
// Top level of the proportional bitmap-font text rasterizer.
`timescale 1ns / 1ps

// Proportional text rasterizer. The block keeps a loadable font (per slot a
// code, height, width and 16-bit pixel rows) and a text cursor. Glyph header
// and glyph row loads, new-line, blank-row, home and unknown commands each
// give one result. A draw request scans the slot attribute memory eight
// slots per cycle, one memory row per cycle, and stops at the first row
// holding a match; it then gives its results: the spans, up to 16, or the
// single cursor result when nothing lands on the board. A missing glyph
// scans every attribute row and gives one missing-glyph result. The scan
// length is set by the single read port of the attribute memory; the span
// phase by the pixel memory, one glyph row per cycle while the consumer
// takes each result. Results sit in an output register, so a stalled
// consumer only holds the block back; one request is worked at a time and
// req_i.ready is high while the block is idle.
// Configuration writes take effect at the next edge and are meant for idle
// periods. No memory clearing is needed after reset: slot valid bits are
// flip-flops, the rest of the font is undefined until loaded.
module proportional_text_rasterizer_unit import ptr_pkg::*; #(
  parameter int GLYPH_SLOTS = 128,
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COLS  = 16,
  parameter int BOARD_ROWS  = 128,
  parameter int BOARD_COLS  = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [8:0] cfg_wdata_i,
  ptr_req_if.sink    req_i,
  ptr_rsp_if.source  rsp_o
);

  localparam int SROWS  = (GLYPH_SLOTS + LANES - 1) / LANES;
  localparam int SROW_W = (SROWS > 1) ? $clog2(SROWS) : 1;

  localparam logic [8:0]  BOARD_WIDTH_RST = 9'd189;
  localparam logic [4:0]  LINE_HEIGHT_RST = 5'd8;
  localparam logic [12:0] BOARD_COLS_L    = 13'(BOARD_COLS);
  localparam logic [16:0] BOARD_ROWS_L    = 17'(BOARD_ROWS);
  localparam logic [8:0]  GLYPH_SLOTS_L   = 9'(GLYPH_SLOTS);
  localparam logic [5:0]  GLYPH_ROWS_L    = 6'(GLYPH_ROWS);
  localparam logic [6:0]  GLYPH_COLS_L    = 7'(GLYPH_COLS);

  typedef enum logic [0:0] {
    REG_BOARD_WIDTH = 1'd0,
    REG_LINE_HEIGHT = 1'd1
  } reg_e;

  typedef enum logic [2:0] {
    CMD_HEADER  = 3'd0,
    CMD_ROW     = 3'd1,
    CMD_DRAW    = 3'd2,
    CMD_NEWLINE = 3'd3,
    CMD_BLANK   = 3'd4,
    CMD_HOME    = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_SPAN     = 2'd0,
    ST_MISSING  = 2'd1,
    ST_CURSOR   = 2'd2,
    ST_LOAD_ACK = 2'd3
  } st_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_PLACE = 5'b00100,
    S_EMIT  = 5'b01000,
    S_ONE   = 5'b10000
  } state_e;

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [4:0] n);
    logic [16:0] s;
    s = {1'b0, a} + {12'd0, n};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // ---------------------------------------------------------------- state
  state_e      state_q;
  st_e         one_st_q;
  logic [8:0]  bw_q;
  logic [4:0]  lh_q;
  logic [15:0] cur_y_q;
  logic [8:0]  cur_x_q;
  logic [7:0]  code_q;
  logic [SROW_W-1:0] scan_row_q;
  logic [7:0]  slot_q;
  logic [4:0]  h_q;
  logic [4:0]  w_q;
  logic [8:0]  x0_q;
  logic [15:0] y0_q;
  logic [15:0] mask_q;
  logic [3:0]  r_q;

  // output register
  logic        out_valid_q;
  st_e         status_q;
  logic [6:0]  board_row_q;
  logic [7:0]  board_col_q;
  logic [15:0] span_bits_q;
  logic [15:0] cursor_row_q;
  logic [8:0]  cursor_col_q;
  logic        last_q;

  // font store
  font_wr_t          font_wr;
  logic [SROW_W-1:0] meta_raddr;
  meta_t [LANES-1:0] meta_rdata;
  logic [LANES-1:0]  use_rdata;
  logic [4:0]        pix_rrow;
  logic [15:0]       pix_rdata;

  // -------------------------------------------------------- request decode
  logic        in_fire;
  logic        out_free;
  logic        out_load;
  cmd_e        cmd;
  logic        slot_ok;
  logic        row_ok;
  logic [4:0]  h_sat;
  logic [4:0]  w_sat;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_fire     = req_i.valid && req_i.ready;
  assign cmd         = cmd_e'(req_i.command);
  assign slot_ok     = {2'b0, req_i.glyph_slot} < GLYPH_SLOTS_L;
  assign row_ok      = {2'b0, req_i.glyph_row} < GLYPH_ROWS_L;
  assign h_sat = ({1'b0, req_i.glyph_height} > GLYPH_ROWS_L[5:0] &&
                  GLYPH_ROWS_L[5:0] != 6'd0) ? GLYPH_ROWS_L[4:0] : req_i.glyph_height;
  assign w_sat = ({2'b0, req_i.glyph_width} > GLYPH_COLS_L)
                 ? GLYPH_COLS_L[4:0] : req_i.glyph_width;

  // loads write the store in the cycle they are taken
  always_comb begin
    font_wr             = '0;
    font_wr.meta_we     = in_fire && (cmd == CMD_HEADER) && slot_ok;
    font_wr.pix_we      = in_fire && (cmd == CMD_ROW) && slot_ok && row_ok;
    font_wr.slot        = {1'b0, req_i.glyph_slot};
    font_wr.in_use      = req_i.glyph_valid;
    font_wr.meta.code   = req_i.char_code;
    font_wr.meta.height = h_sat;
    font_wr.meta.width  = w_sat;
    font_wr.row         = {1'b0, req_i.glyph_row};
    font_wr.bits        = req_i.row_bits;
  end

  // --------------------------------------------------------- slot scan
  // Attribute row scan_row_q is on the read port; the lowest matching lane wins.
  logic              hit;
  logic [LANE_W-1:0] hit_lane;

  always_comb begin
    hit      = 1'b0;
    hit_lane = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (use_rdata[i] && meta_rdata[i].code == code_q) begin
        hit      = 1'b1;
        hit_lane = LANE_W'(i);
      end
    end
  end

  // idle prefetches row 0 so a draw has its first row at the next edge
  assign meta_raddr = (state_q == S_SCAN) ? (scan_row_q + SROW_W'(1)) : '0;

  // ------------------------------------------------------- placement
  logic        wrap;
  logic [15:0] y0_w;
  logic [8:0]  x0_w;
  logic [12:0] limit;
  logic [12:0] room;
  logic [4:0]  avail_w;
  logic [4:0]  avail;
  logic [15:0] mask_w;
  logic        row0_ok;

  always_comb begin
    wrap    = ({1'b0, cur_x_q} + {5'd0, w_q}) >= {1'b0, bw_q};
    y0_w    = wrap ? sat_add(cur_y_q, lh_q) : cur_y_q;
    x0_w    = wrap ? 9'd0 : cur_x_q;
    limit   = ({4'd0, bw_q} < BOARD_COLS_L) ? {4'd0, bw_q} : BOARD_COLS_L;
    room    = (limit > {4'd0, x0_w}) ? (limit - {4'd0, x0_w}) : 13'd0;
    avail_w = (room < {8'd0, w_q}) ? room[4:0] : w_q;
    avail   = (avail_w > 5'd16) ? 5'd16 : avail_w;
    mask_w  = (avail >= 5'd16) ? 16'hFFFF : 16'((17'd1 << avail) - 17'd1);
    row0_ok = (h_q != 5'd0) && ({1'b0, y0_w} < BOARD_ROWS_L);
  end

  // ---------------------------------------------------------- spans
  logic [4:0]  r_next;
  logic [16:0] br;
  logic [16:0] br_next;
  logic        span_last;

  assign r_next    = {1'b0, r_q} + 5'd1;
  assign br        = {1'b0, y0_q} + {13'd0, r_q};
  assign br_next   = {1'b0, y0_q} + {12'd0, r_next};
  assign span_last = !((r_next < h_q) && (r_next < 5'd16) && (br_next < BOARD_ROWS_L));

  assign out_free = !out_valid_q || rsp_o.ready;
  assign out_load = out_free && ((state_q == S_EMIT) || (state_q == S_ONE));

  // pixel read runs one row ahead of the span being sent
  assign pix_rrow = (state_q == S_EMIT && out_free) ? r_next : {1'b0, r_q};

  ptr_font_store #(
    .GLYPH_SLOTS (GLYPH_SLOTS),
    .GLYPH_ROWS  (GLYPH_ROWS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (font_wr),
    .meta_raddr_i (meta_raddr),
    .meta_rdata_o (meta_rdata),
    .use_rdata_o  (use_rdata),
    .pix_rslot_i  (slot_q),
    .pix_rrow_i   (pix_rrow),
    .pix_rdata_o  (pix_rdata)
  );

  // ------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      one_st_q    <= ST_CURSOR;
      bw_q        <= BOARD_WIDTH_RST;
      lh_q        <= LINE_HEIGHT_RST;
      cur_y_q     <= '0;
      cur_x_q     <= '0;
      code_q      <= '0;
      scan_row_q  <= '0;
      slot_q      <= '0;
      h_q         <= '0;
      w_q         <= '0;
      x0_q        <= '0;
      y0_q        <= '0;
      mask_q      <= '0;
      r_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_index_i))
          REG_BOARD_WIDTH: bw_q <= cfg_wdata_i;
          REG_LINE_HEIGHT: lh_q <= cfg_wdata_i[4:0];
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            unique case (cmd) inside
              CMD_HEADER, CMD_ROW: begin
                one_st_q <= ST_LOAD_ACK;
                state_q  <= S_ONE;
              end
              CMD_DRAW: begin
                code_q     <= req_i.char_code;
                scan_row_q <= '0;
                state_q    <= S_SCAN;
              end
              CMD_NEWLINE: begin
                cur_y_q  <= sat_add(cur_y_q, lh_q);
                cur_x_q  <= '0;
                one_st_q <= ST_CURSOR;
                state_q  <= S_ONE;
              end
              CMD_BLANK: begin
                cur_y_q  <= sat_add(cur_y_q, 5'd1);
                cur_x_q  <= '0;
                one_st_q <= ST_CURSOR;
                state_q  <= S_ONE;
              end
              CMD_HOME: begin
                cur_y_q  <= '0;
                cur_x_q  <= '0;
                one_st_q <= ST_CURSOR;
                state_q  <= S_ONE;
              end
              default: begin
                // undefined command codes: acknowledge, change nothing
                one_st_q <= ST_CURSOR;
                state_q  <= S_ONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            slot_q  <= 8'({scan_row_q, hit_lane});
            h_q     <= meta_rdata[hit_lane].height;
            w_q     <= meta_rdata[hit_lane].width;
            r_q     <= '0;
            state_q <= S_PLACE;
          end else if (scan_row_q == SROW_W'(SROWS - 1)) begin
            one_st_q <= ST_MISSING;
            state_q  <= S_ONE;
          end else begin
            scan_row_q <= scan_row_q + SROW_W'(1);
          end
        end
        S_PLACE: begin
          // wrap first, then the cursor moves past the glyph
          cur_y_q <= y0_w;
          cur_x_q <= x0_w + {4'd0, w_q};
          x0_q    <= x0_w;
          y0_q    <= y0_w;
          mask_q  <= mask_w;
          if (row0_ok) begin
            state_q <= S_EMIT;
          end else begin
            one_st_q <= ST_CURSOR;
            state_q  <= S_ONE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (span_last) begin
              state_q <= S_IDLE;
            end else begin
              r_q <= r_q + 4'd1;
            end
          end
        end
        S_ONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ------------------------------------------------- result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cursor_row_q <= cur_y_q;
      cursor_col_q <= cur_x_q;
      if (state_q == S_EMIT) begin
        status_q    <= ST_SPAN;
        board_row_q <= br[6:0];
        board_col_q <= x0_q[7:0];
        span_bits_q <= pix_rdata & mask_q;
        last_q      <= span_last;
      end else begin
        status_q    <= one_st_q;
        board_row_q <= '0;
        board_col_q <= '0;
        span_bits_q <= '0;
        last_q      <= 1'b1;
      end
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.board_row  = board_row_q;
  assign rsp_o.board_col  = board_col_q;
  assign rsp_o.span_bits  = span_bits_q;
  assign rsp_o.cursor_row = cursor_row_q;
  assign rsp_o.cursor_col = cursor_col_q;
  assign rsp_o.last       = last_q;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

  a_nonspan_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_SPAN |-> last_q)
    else $error("single-result status without last");

  a_nonspan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_SPAN |->
      board_row_q == 7'd0 && board_col_q == 8'd0 && span_bits_q == 16'd0)
    else $error("span fields set on a non-span result");

  a_emit_in_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT |-> ({1'b0, r_q} < h_q) && (br < BOARD_ROWS_L))
    else $error("span row beyond glyph height or board");
`endif

endmodule
